@@ sv/lh_pkg.sv @@
// Shared types, constants and helper functions for the latency log2 histogram.
package lh_pkg;

    localparam int BUCKET_COUNT    = 32;
    localparam int RESERVOIR_DEPTH = 64;

    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;
    localparam int PCT_W     = 17;
    localparam int PCT_FRAC  = 16;
    localparam int BKT_IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int RES_IDX_W = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam int FILL_W    = $clog2(RESERVOIR_DEPTH + 1);
    localparam int RUN_W     = VAL_W + BKT_IDX_W + 1;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 192;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BKT_RD,
        ST_BKT_WR,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_QRY_CHK,
        ST_EX_RD,
        ST_EX_WAIT,
        ST_WK_RD,
        ST_WK_ACC,
        ST_FINISH
    } lh_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic bkt_rd;
        logic bkt_wr;
        logic ins_start;
        logic ins_step;
        logic ins_put;
        logic qry_chk;
        logic ex_rd;
        logic ex_take;
        logic wk_rd;
        logic wk_acc;
        logic finish;
    } lh_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ins_needed;
        logic fill_zero;
        logic ins_gt;
        logic pos_one;
        logic special;
        logic exact;
        logic wk_hit;
        logic wk_last;
        logic out_free;
    } lh_sts_t;

    // Floor log2 of a sample, clamped to the last bucket
    function automatic logic [BKT_IDX_W-1:0] lh_log2(input logic [VAL_W-1:0] v);
        logic [BKT_IDX_W-1:0] b;
        b = '0;
        for (int k = 1; k < VAL_W; k++) begin
            if (v[k]) begin
                b = (k > BUCKET_COUNT - 1) ? BKT_IDX_W'(BUCKET_COUNT - 1) : BKT_IDX_W'(k);
            end
        end
        return b;
    endfunction

    // Midpoint of bucket i, saturated to the sample range
    function automatic logic [VAL_W-1:0] lh_mid(input logic [BKT_IDX_W-1:0] i);
        logic [VAL_W+1:0] m;
        if (i == '0) begin
            m = (VAL_W+2)'(1);
        end else begin
            m = (VAL_W+2)'(3) << (i - 1'b1);
        end
        return (m > (VAL_W+2)'(VAL_MAX)) ? VAL_MAX : m[VAL_W-1:0];
    endfunction

endpackage

@@ sv/latency_log2_histogram.sv @@
// Latency histogram with log2 buckets, min/max/sum and percentile query.
// An add item updates its bucket and, while the reservoir is not full, inserts the sample in sorted
// order (an empty reservoir takes it directly), shifting larger stored samples up. A query resolves
// the special cases directly, reads the reservoir on the exact path, or else walks the buckets.
// One item is in work at a time; the result waits in an output register.
// aresetn is synchronous active low; it clears all statistics and the bucket valid bits.
module latency_log2_histogram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lh_pkg::S_TDATA_W-1:0]  s_tdata,  // sample_value[31:0], pct_q16[48:32]
    input  logic                          s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // total_count[31:0], total_sum[95:32], least_seen[127:96],
    // greatest_seen[159:128], percentile_value[191:160]
    output logic [lh_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lh_pkg::*;

    lh_cmd_t cmd;
    lh_sts_t sts;

    lh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_func  (s_tuser),
        .in_value (s_tdata[VAL_W-1:0]),
        .in_pct   (s_tdata[VAL_W +: PCT_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sv/lh_ctrl.sv @@
// Controller state machine that sequences add and query items.
module lh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_func,
    output logic            s_tready,
    input  lh_pkg::lh_sts_t sts,
    output lh_pkg::lh_cmd_t cmd
);
    import lh_pkg::*;

    lh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_func ? ST_QRY_CHK : ST_BKT_RD;
                end
            end
            ST_BKT_RD: state_next = ST_BKT_WR;
            ST_BKT_WR: begin
                if (sts.ins_needed && !sts.fill_zero) begin
                    state_next = ST_INS_CMP;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_INS_CMP: begin
                priority if (!sts.ins_gt) state_next = ST_FINISH;
                else if (sts.pos_one)     state_next = ST_INS_PUT;
                else                      state_next = ST_INS_CMP;
            end
            ST_INS_PUT: state_next = ST_FINISH;
            ST_QRY_CHK: begin
                priority if (sts.special) state_next = ST_FINISH;
                else if (sts.exact)       state_next = ST_EX_RD;
                else                      state_next = ST_WK_RD;
            end
            ST_EX_RD:   state_next = ST_EX_WAIT;
            ST_EX_WAIT: state_next = ST_FINISH;
            ST_WK_RD:   state_next = ST_WK_ACC;
            ST_WK_ACC: begin
                if (sts.wk_hit || sts.wk_last) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_WK_RD;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_BKT_RD:  cmd.bkt_rd = 1'b1;
            ST_BKT_WR: begin
                cmd.bkt_wr    = 1'b1;
                cmd.ins_start = sts.ins_needed;
            end
            ST_INS_CMP: cmd.ins_step = 1'b1;
            ST_INS_PUT: cmd.ins_put  = 1'b1;
            ST_QRY_CHK: cmd.qry_chk  = 1'b1;
            ST_EX_RD:   cmd.ex_rd    = 1'b1;
            ST_EX_WAIT: cmd.ex_take  = 1'b1;
            ST_WK_RD:   cmd.wk_rd    = 1'b1;
            ST_WK_ACC:  cmd.wk_acc   = 1'b1;
            ST_FINISH:  cmd.finish   = sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/lh_datapath.sv @@
// Datapath: statistics registers, bucket memory, sorted reservoir, query math, output item.
module lh_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lh_pkg::lh_cmd_t               cmd,
    output lh_pkg::lh_sts_t               sts,
    input  logic                          in_func,
    input  logic [lh_pkg::VAL_W-1:0]      in_value,
    input  logic [lh_pkg::PCT_W-1:0]      in_pct,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lh_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lh_pkg::*;

    logic [VAL_W-1:0]     total_reg, min_reg, max_reg, val_reg, ans_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [PCT_W-1:0]     pct_reg;
    logic [BKT_IDX_W-1:0] bidx_reg, walk_reg;
    logic [RES_IDX_W-1:0] pos_reg, exidx_reg;
    logic [VAL_W-1:0]     target_reg;
    logic [RUN_W-1:0]     run_reg;
    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_reg;

    // Bucket store with per-entry valid bits cleared at reset
    logic [VAL_W-1:0]        bkt_mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] bkt_vld_reg;
    logic [VAL_W-1:0]        bkt_rdata_reg;
    logic [BKT_IDX_W-1:0]    bkt_raddr;

    // Sorted reservoir
    logic [VAL_W-1:0]     res_mem [RESERVOIR_DEPTH];
    logic [VAL_W-1:0]     res_rdata_reg;
    logic [RES_IDX_W-1:0] res_raddr, res_waddr;
    logic [VAL_W-1:0]     res_wdata;
    logic                 res_we;

    logic                 ins_gt;
    logic [RUN_W-1:0]     run_next;
    logic [VAL_W+PCT_W-1:0]  tgt_prod;
    logic [FILL_W+PCT_W-1:0] idx_prod;
    logic [FILL_W-1:0]    fill_m1;
    logic                 is_special, is_exact;

    assign ins_gt   = res_rdata_reg > val_reg;
    assign run_next = run_reg + RUN_W'(bkt_rdata_reg);
    assign fill_m1  = fill_reg - 1'b1;
    assign tgt_prod = (VAL_W+PCT_W)'(total_reg) * (VAL_W+PCT_W)'(pct_reg);
    assign idx_prod = (FILL_W+PCT_W)'(fill_m1) * (FILL_W+PCT_W)'(pct_reg);
    assign is_special = (total_reg == '0) || (pct_reg == '0) || pct_reg[PCT_FRAC];
    assign is_exact   = (fill_reg != '0) && (total_reg == VAL_W'(fill_reg));

    always_comb begin
        sts.ins_needed = fill_reg < FILL_W'(RESERVOIR_DEPTH);
        sts.fill_zero  = fill_reg == '0;
        sts.ins_gt     = ins_gt;
        sts.pos_one    = pos_reg == RES_IDX_W'(1);
        sts.special    = is_special;
        sts.exact      = is_exact;
        sts.wk_hit     = run_next >= RUN_W'(target_reg);
        sts.wk_last    = walk_reg == BKT_IDX_W'(BUCKET_COUNT - 1);
        sts.out_free   = !out_vld_reg || m_tready;
    end

    // Item capture and running statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end else if (cmd.load && !in_func) begin
            if (total_reg != VAL_MAX) total_reg <= total_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(in_value);
            if (in_value < min_reg) min_reg <= in_value;
            if (in_value > max_reg) max_reg <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg  <= in_value;
            pct_reg  <= in_pct;
            bidx_reg <= lh_log2(in_value);
        end
    end

    // Bucket memory: one read address, one write address
    assign bkt_raddr = cmd.wk_rd ? walk_reg : bidx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.bkt_rd || cmd.wk_rd) begin
            bkt_rdata_reg <= bkt_vld_reg[bkt_raddr] ? bkt_mem[bkt_raddr] : '0;
        end
        if (cmd.bkt_wr) begin
            bkt_mem[bidx_reg] <= (bkt_rdata_reg == VAL_MAX) ? bkt_rdata_reg
                                                           : bkt_rdata_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bkt_vld_reg <= '0;
        end else if (cmd.bkt_wr) begin
            bkt_vld_reg[bidx_reg] <= 1'b1;
        end
    end

    // Reservoir addressing for insertion and exact lookup
    always_comb begin
        priority if (cmd.ex_rd)   res_raddr = exidx_reg;
        else if (cmd.ins_start)   res_raddr = fill_m1[RES_IDX_W-1:0];
        else                      res_raddr = pos_reg - RES_IDX_W'(2);
    end

    always_comb begin
        res_we    = 1'b0;
        res_waddr = pos_reg;
        res_wdata = val_reg;
        priority if (cmd.ins_start) begin
            res_we    = fill_reg == '0;
            res_waddr = '0;
        end else if (cmd.ins_step) begin
            res_we    = 1'b1;
            res_wdata = ins_gt ? res_rdata_reg : val_reg;
        end else if (cmd.ins_put) begin
            res_we    = 1'b1;
        end else begin
            res_we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        res_rdata_reg <= res_mem[res_raddr];
        if (res_we) res_mem[res_waddr] <= res_wdata;
    end

    // Insertion position and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.ins_start) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_start) begin
            pos_reg <= fill_reg[RES_IDX_W-1:0];
        end else if (cmd.ins_step && ins_gt) begin
            pos_reg <= pos_reg - 1'b1;
        end
    end

    // Query setup, bucket walk and answer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ans_reg <= '0;
        end else if (cmd.qry_chk) begin
            target_reg <= tgt_prod[PCT_FRAC +: VAL_W];
            exidx_reg  <= RES_IDX_W'(idx_prod[FILL_W+PCT_W-1:PCT_FRAC]);
            walk_reg   <= '0;
            run_reg    <= '0;
            if (is_special) begin
                priority if (total_reg == '0) ans_reg <= '0;
                else if (pct_reg == '0)       ans_reg <= min_reg;
                else                          ans_reg <= max_reg;
            end
        end else if (cmd.ex_take) begin
            ans_reg <= res_rdata_reg;
        end else if (cmd.wk_acc) begin
            run_reg  <= run_next;
            walk_reg <= walk_reg + 1'b1;
            if (sts.wk_hit)        ans_reg <= lh_mid(walk_reg);
            else if (sts.wk_last)  ans_reg <= max_reg;
        end
    end

    // Output item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= {ans_reg, max_reg, (total_reg == '0) ? {VAL_W{1'b0}} : min_reg,
                        sum_reg, total_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule
